>>> sv/srsw_pkg.sv
// shared types and constants for the selective repeat sender window
// no dependencies; used by the top, front and back modules of the block
package srsw_pkg;

   // request codes on the input channel
   localparam logic [1:0] REQ_SEND = 2'd0;
   localparam logic [1:0] REQ_ACK  = 2'd1;
   localparam logic [1:0] REQ_TICK = 2'd2;

   // result kinds
   localparam logic [2:0] KIND_SENT    = 3'd0;
   localparam logic [2:0] KIND_FULL    = 3'd1;
   localparam logic [2:0] KIND_NONE    = 3'd2;
   localparam logic [2:0] KIND_TAKEN   = 3'd3;
   localparam logic [2:0] KIND_IGNORED = 3'd4;
   localparam logic [2:0] KIND_RESEND  = 3'd5;

   // configuration register indexes
   localparam logic [1:0] CSR_WINDOW_LENGTH = 2'd0;
   localparam logic [1:0] CSR_TOTAL_PACKETS = 2'd1;
   localparam logic [1:0] CSR_ADAPTIVE_MODE = 2'd2;
   localparam logic [1:0] CSR_START_TIMEOUT = 2'd3;

   // reset values of the configuration
   localparam logic [4:0]  RESET_WINDOW_LENGTH = 5'd4;
   localparam logic [31:0] RESET_TOTAL_PACKETS = 32'd1;
   localparam logic [31:0] RESET_START_TIMEOUT = 32'd500000;
   localparam logic [31:0] TIMEOUT_MAX         = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [39:0] now_us;
      logic [31:0] ack_seq;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  result_kind;
      logic [31:0] seq_num;
      logic [31:0] window_base;
      logic [31:0] current_timeout_out;
      logic        transfer_done;
      logic        last_of_run;
   } rsp_item_type;

   typedef enum logic [1:0] {
      OP_SEND,
      OP_ACK,
      OP_TICK
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [39:0] now_us;
      logic [31:0] ack_seq;
   } cmd_item_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEND_MOD,
      ST_ACK_MOD,
      ST_ACK_CHK,
      ST_RTT_EST,
      ST_RTT_DEV,
      ST_RTT_TMO,
      ST_SLIDE_START,
      ST_SLIDE_RD,
      ST_SLIDE_CHK,
      ST_TICK_RD,
      ST_TICK_CHK,
      ST_EMIT
   } back_state_type;

endpackage

>>> sv/selective_repeat_sender_window.sv
// selective repeat sender window; one request at a time in the back end.
// send: the bit-serial slot index unit finds the slot, which is then claimed.
// ack: slot index, slot check, rtt update if adaptive, then the base slides.
// tick: unless done, each window slot is read and checked for a due resend.
// reset (synchronous): window empty, base and next sequence zero, config to defaults.
// depends on srsw_pkg, srsw_front, srsw_back, srsw_fifo
module selective_repeat_sender_window #(
   parameter int WIN_MAX   = 16,
   parameter int TIME_BITS = 40,
   parameter int SEQ_BITS  = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  srsw_pkg::req_item_type req_data,
   output logic                   req_full,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output srsw_pkg::rsp_item_type rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [31:0]            csr_wdata
);
   logic                   cmd_valid, cmd_take;
   srsw_pkg::cmd_item_type cmd_data;
   logic                   res_push, res_full;
   srsw_pkg::rsp_item_type res_data;

   assign csr_ready = 1'b1;

   // request intake
   srsw_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_take  (cmd_take)
   );

   // window engine
   srsw_back #(
      .WIN_MAX   (WIN_MAX),
      .TIME_BITS (TIME_BITS),
      .SEQ_BITS  (SEQ_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_take  (cmd_take),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_push  (res_push),
      .rsp_data  (res_data),
      .rsp_full  (res_full)
   );

   // result queue
   srsw_fifo #(
      .item_type (srsw_pkg::rsp_item_type),
      .DEPTH     (4)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );
endmodule

>>> sv/srsw_fifo.sv
// small first-in first-out queue of any packed item type
// no dependencies; used for the command queue and the result queue
module srsw_fifo #(
   parameter type item_type = logic,
   parameter int  DEPTH     = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_data,
   output logic     full,
   input  logic     pop,
   output item_type pop_data,
   output logic     empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type          mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

>>> sv/srsw_front.sv
// front end: takes request transactions, drops unknown codes, queues commands
// depends on srsw_pkg and srsw_fifo
module srsw_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  srsw_pkg::req_item_type req_data,
   output logic                 req_full,
   output logic                 cmd_valid,
   output srsw_pkg::cmd_item_type cmd_data,
   input  logic                 cmd_take
);
   srsw_pkg::cmd_item_type cmd_new;
   logic                   known;
   logic                   q_full, q_empty;

   // classify the request code
   always_comb begin
      known       = 1'b1;
      cmd_new.op  = srsw_pkg::OP_SEND;
      cmd_new.now_us  = req_data.now_us;
      cmd_new.ack_seq = req_data.ack_seq;
      case (req_data.req_type)
         srsw_pkg::REQ_SEND: cmd_new.op = srsw_pkg::OP_SEND;
         srsw_pkg::REQ_ACK:  cmd_new.op = srsw_pkg::OP_ACK;
         srsw_pkg::REQ_TICK: cmd_new.op = srsw_pkg::OP_TICK;
         default:            known = 1'b0;
      endcase
   end

   assign req_full  = q_full;
   assign cmd_valid = !q_empty;

   // command queue toward the back end
   srsw_fifo #(
      .item_type (srsw_pkg::cmd_item_type),
      .DEPTH     (2)
   ) u_cmd_q (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push && known),
      .push_data (cmd_new),
      .full      (q_full),
      .pop       (cmd_take),
      .pop_data  (cmd_data),
      .empty     (q_empty)
   );
endmodule

>>> sv/srsw_mod.sv
// iterative remainder unit: sequence number modulo window size, one bit a cycle
// depends on nothing outside this file
module srsw_mod #(
   parameter int SEQ_BITS = 32,
   parameter int CNT_W    = 5,
   parameter int SLOT_W   = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [SEQ_BITS-1:0] dividend,
   input  logic [CNT_W-1:0]    divisor,
   output logic                done,
   output logic [SLOT_W-1:0]   rem
);
   localparam int STEP_W = $clog2(SEQ_BITS + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [SEQ_BITS-1:0] shreg_ff, shreg_in;
   logic [CNT_W-1:0]    rem_ff, rem_in;
   logic [CNT_W-1:0]    div_ff, div_in;
   logic [CNT_W:0]      trial;

   assign done = done_ff;
   assign rem  = SLOT_W'(rem_ff);

   // restoring remainder step
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      shreg_in = shreg_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      trial    = {rem_ff, shreg_ff[SEQ_BITS-1]};
      if (start) begin
         busy_in  = 1'b1;
         step_in  = STEP_W'(SEQ_BITS);
         shreg_in = dividend;
         rem_in   = '0;
         div_in   = divisor;
      end else if (busy_ff) begin
         shreg_in = shreg_ff << 1;
         if (trial >= {1'b0, div_ff}) begin
            rem_in = CNT_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = CNT_W'(trial);
         end
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      shreg_ff <= shreg_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
   end
endmodule

>>> sv/srsw_back.sv
// back end: window state, slot memory, rtt estimator and result generation
// depends on srsw_pkg and srsw_mod
module srsw_back #(
   parameter int WIN_MAX   = 16,
   parameter int TIME_BITS = 40,
   parameter int SEQ_BITS  = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   input  srsw_pkg::cmd_item_type cmd_data,
   output logic                   cmd_take,
   input  logic                   csr_valid,
   input  logic [1:0]             csr_index,
   input  logic [31:0]            csr_wdata,
   output logic                   rsp_push,
   output srsw_pkg::rsp_item_type rsp_data,
   input  logic                   rsp_full
);
   localparam int SLOT_W = (WIN_MAX > 1) ? $clog2(WIN_MAX) : 1;
   localparam int CNT_W  = $clog2(WIN_MAX + 1);

   typedef struct packed {
      logic [SEQ_BITS-1:0]  seq;
      logic [TIME_BITS-1:0] stamp;
   } slot_entry_type;

   // configuration
   logic [4:0]  wl_ff;
   logic [31:0] total_ff;
   logic        adapt_ff;

   // window state
   srsw_pkg::back_state_type state_ff, state_in;
   srsw_pkg::cmd_item_type   cmd_ff, cmd_in;
   logic [SEQ_BITS-1:0]  base_ff, base_in;
   logic [SEQ_BITS-1:0]  next_ff, next_in;
   logic [WIN_MAX-1:0]   filled_ff, filled_in;
   logic [WIN_MAX-1:0]   acked_ff, acked_in;
   logic [WIN_MAX-1:0]   resent_ff, resent_in;
   logic [TIME_BITS-1:0] est_ff, est_in;
   logic [TIME_BITS-1:0] dev_ff, dev_in;
   logic [TIME_BITS-1:0] sample_ff, sample_in;
   logic [31:0]          timeout_ff, timeout_in;
   logic                 done_ff, done_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [2:0]           res_kind_ff, res_kind_in;
   logic [31:0]          res_seq_ff, res_seq_in;
   logic                 pend_ff, pend_in;

   // slot memory
   slot_entry_type       mem_ff [WIN_MAX];
   slot_entry_type       rd_ff;
   logic [SLOT_W-1:0]    rd_addr;
   logic                 mem_we;
   logic [SLOT_W-1:0]    mem_wa;
   slot_entry_type       mem_wd;

   // helpers
   logic [CNT_W-1:0]     win;
   logic                 mod_start, mod_done;
   logic [SEQ_BITS-1:0]  mod_dividend;
   logic [SLOT_W-1:0]    mod_rem;
   logic [TIME_BITS-1:0] now_t;
   logic [SEQ_BITS-1:0]  sq;
   logic [SLOT_W-1:0]    idx;
   logic [TIME_BITS-1:0] gap;
   logic [33:0]          tmo_sum;
   logic                 last_flag;
   logic                 tick_due;

   // effective window size, clamped to 1..WIN_MAX
   always_comb begin
      if (wl_ff == '0) begin
         win = CNT_W'(1);
      end else if (32'(wl_ff) > WIN_MAX) begin
         win = CNT_W'(WIN_MAX);
      end else begin
         win = CNT_W'(wl_ff);
      end
   end

   assign now_t   = TIME_BITS'(cmd_ff.now_us);
   assign sq      = SEQ_BITS'(cmd_ff.ack_seq);
   assign idx     = cnt_ff[SLOT_W-1:0];
   assign gap     = (sample_ff >= est_ff) ? sample_ff - est_ff : est_ff - sample_ff;
   assign tmo_sum = 34'(est_ff[31:0]) + {2'b00, dev_ff[29:0], 2'b00};
   assign tick_due = filled_ff[idx] && !acked_ff[idx] &&
                     ((now_t - rd_ff.stamp) > TIME_BITS'(timeout_ff));

   // result transaction toward the output queue
   assign rsp_data.result_kind         = res_kind_ff;
   assign rsp_data.seq_num             = res_seq_ff;
   assign rsp_data.window_base         = 32'(base_ff);
   assign rsp_data.current_timeout_out = timeout_ff;
   assign rsp_data.transfer_done       = done_ff;
   assign rsp_data.last_of_run         = last_flag;

   // sequencer
   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      base_in     = base_ff;
      next_in     = next_ff;
      filled_in   = filled_ff;
      acked_in    = acked_ff;
      resent_in   = resent_ff;
      est_in      = est_ff;
      dev_in      = dev_ff;
      sample_in   = sample_ff;
      timeout_in  = timeout_ff;
      done_in     = done_ff;
      slot_in     = slot_ff;
      cnt_in      = cnt_ff;
      res_kind_in = res_kind_ff;
      res_seq_in  = res_seq_ff;
      pend_in     = pend_ff;
      cmd_take    = 1'b0;
      rsp_push    = 1'b0;
      last_flag   = 1'b1;
      mod_start   = 1'b0;
      mod_dividend = next_ff;
      rd_addr     = idx;
      mem_we      = 1'b0;
      mem_wa      = slot_ff;
      mem_wd.seq  = next_ff;
      mem_wd.stamp = now_t;

      case (state_ff)
         srsw_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               cmd_take = 1'b1;
               cmd_in   = cmd_data;
               case (cmd_data.op)
                  srsw_pkg::OP_SEND: begin
                     res_seq_in = 32'(next_ff);
                     if ((next_ff - base_ff) >= SEQ_BITS'(win)) begin
                        res_kind_in = srsw_pkg::KIND_FULL;
                        state_in    = srsw_pkg::ST_EMIT;
                     end else if (done_ff || (32'(next_ff) >= total_ff)) begin
                        res_kind_in = srsw_pkg::KIND_NONE;
                        state_in    = srsw_pkg::ST_EMIT;
                     end else begin
                        mod_start = 1'b1;
                        state_in  = srsw_pkg::ST_SEND_MOD;
                     end
                  end
                  srsw_pkg::OP_ACK: begin
                     res_kind_in = srsw_pkg::KIND_IGNORED;
                     res_seq_in  = cmd_data.ack_seq;
                     if (done_ff ||
                         ((SEQ_BITS'(cmd_data.ack_seq) - base_ff) >= SEQ_BITS'(win))) begin
                        state_in = srsw_pkg::ST_EMIT;
                     end else begin
                        mod_start    = 1'b1;
                        mod_dividend = SEQ_BITS'(cmd_data.ack_seq);
                        state_in     = srsw_pkg::ST_ACK_MOD;
                     end
                  end
                  srsw_pkg::OP_TICK: begin
                     cnt_in  = '0;
                     pend_in = 1'b0;
                     if (!done_ff) begin
                        state_in = srsw_pkg::ST_TICK_RD;
                     end
                  end
                  default: state_in = srsw_pkg::ST_IDLE;
               endcase
            end
         end

         // claim the slot of the next sequence number
         srsw_pkg::ST_SEND_MOD: begin
            if (mod_done) begin
               filled_in[mod_rem] = 1'b1;
               acked_in[mod_rem]  = 1'b0;
               resent_in[mod_rem] = 1'b0;
               mem_we       = 1'b1;
               mem_wa       = mod_rem;
               mem_wd.seq   = next_ff;
               mem_wd.stamp = now_t;
               res_kind_in  = srsw_pkg::KIND_SENT;
               next_in      = next_ff + 1'b1;
               state_in     = srsw_pkg::ST_EMIT;
            end
         end

         srsw_pkg::ST_ACK_MOD: begin
            rd_addr = mod_rem;
            if (mod_done) begin
               slot_in  = mod_rem;
               state_in = srsw_pkg::ST_ACK_CHK;
            end
         end

         // check the slot against the acknowledged sequence number
         srsw_pkg::ST_ACK_CHK: begin
            if (!filled_ff[slot_ff] || acked_ff[slot_ff] || (rd_ff.seq != sq)) begin
               state_in = srsw_pkg::ST_EMIT;
            end else begin
               acked_in[slot_ff] = 1'b1;
               res_kind_in = srsw_pkg::KIND_TAKEN;
               res_seq_in  = 32'(sq);
               sample_in   = now_t - rd_ff.stamp;
               if (adapt_ff && !resent_ff[slot_ff]) begin
                  state_in = srsw_pkg::ST_RTT_EST;
               end else begin
                  state_in = srsw_pkg::ST_SLIDE_START;
               end
            end
         end

         // estimator: smoothed rtt, deviation, then timeout
         srsw_pkg::ST_RTT_EST: begin
            est_in   = est_ff - (est_ff >> 3) + (sample_ff >> 3);
            state_in = srsw_pkg::ST_RTT_DEV;
         end
         srsw_pkg::ST_RTT_DEV: begin
            dev_in   = dev_ff - (dev_ff >> 2) + (gap >> 2);
            state_in = srsw_pkg::ST_RTT_TMO;
         end
         srsw_pkg::ST_RTT_TMO: begin
            if ((est_ff > TIME_BITS'(32'hFFFF_FFFF)) || (dev_ff > TIME_BITS'(32'h3FFF_FFFF)) ||
                (tmo_sum[33:32] != 2'b00)) begin
               timeout_in = srsw_pkg::TIMEOUT_MAX;
            end else begin
               timeout_in = tmo_sum[31:0];
            end
            state_in = srsw_pkg::ST_SLIDE_START;
         end

         srsw_pkg::ST_SLIDE_START: begin
            cnt_in = '0;
            if (sq == base_ff) begin
               state_in = srsw_pkg::ST_SLIDE_RD;
            end else begin
               state_in = srsw_pkg::ST_EMIT;
            end
         end

         srsw_pkg::ST_SLIDE_RD: begin
            rd_addr  = slot_ff;
            state_in = srsw_pkg::ST_SLIDE_CHK;
         end

         // move the base past one acknowledged slot
         srsw_pkg::ST_SLIDE_CHK: begin
            if (filled_ff[slot_ff] && acked_ff[slot_ff] && (rd_ff.seq == base_ff)) begin
               if ((33'(base_ff) + 33'd1) == 33'(total_ff)) begin
                  done_in = 1'b1;
               end
               filled_in[slot_ff] = 1'b0;
               acked_in[slot_ff]  = 1'b0;
               resent_in[slot_ff] = 1'b0;
               base_in = base_ff + 1'b1;
               if ((base_in == '0) || ((32'(slot_ff) + 1) == 32'(win))) begin
                  slot_in = '0;
               end else begin
                  slot_in = slot_ff + 1'b1;
               end
               cnt_in = cnt_ff + 1'b1;
               if ((32'(cnt_ff) + 1) == 32'(win)) begin
                  state_in = srsw_pkg::ST_EMIT;
               end else begin
                  state_in = srsw_pkg::ST_SLIDE_RD;
               end
            end else begin
               state_in = srsw_pkg::ST_EMIT;
            end
         end

         srsw_pkg::ST_TICK_RD: begin
            state_in = srsw_pkg::ST_TICK_CHK;
         end

         // resend check; the previous resend goes out once a later one is found
         srsw_pkg::ST_TICK_CHK: begin
            if (!(tick_due && pend_ff && rsp_full)) begin
               if (tick_due) begin
                  resent_in[idx] = 1'b1;
                  mem_we       = 1'b1;
                  mem_wa       = idx;
                  mem_wd.seq   = rd_ff.seq;
                  mem_wd.stamp = now_t;
                  if (pend_ff) begin
                     rsp_push  = 1'b1;
                     last_flag = 1'b0;
                  end
                  res_kind_in = srsw_pkg::KIND_RESEND;
                  res_seq_in  = 32'(rd_ff.seq);
                  pend_in     = 1'b1;
               end
               cnt_in = cnt_ff + 1'b1;
               if ((32'(cnt_ff) + 1) == 32'(win)) begin
                  if (pend_in) begin
                     state_in = srsw_pkg::ST_EMIT;
                  end else begin
                     state_in = srsw_pkg::ST_IDLE;
                  end
               end else begin
                  state_in = srsw_pkg::ST_TICK_RD;
               end
            end
         end

         srsw_pkg::ST_EMIT: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               pend_in  = 1'b0;
               state_in = srsw_pkg::ST_IDLE;
            end
         end

         default: state_in = srsw_pkg::ST_IDLE;
      endcase
   end

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= srsw_pkg::ST_IDLE;
         base_ff    <= '0;
         next_ff    <= '0;
         filled_ff  <= '0;
         acked_ff   <= '0;
         resent_ff  <= '0;
         est_ff     <= '0;
         dev_ff     <= '0;
         timeout_ff <= srsw_pkg::RESET_START_TIMEOUT;
         done_ff    <= 1'b0;
         pend_ff    <= 1'b0;
         wl_ff      <= srsw_pkg::RESET_WINDOW_LENGTH;
         total_ff   <= srsw_pkg::RESET_TOTAL_PACKETS;
         adapt_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         base_ff    <= base_in;
         next_ff    <= next_in;
         filled_ff  <= filled_in;
         acked_ff   <= acked_in;
         resent_ff  <= resent_in;
         est_ff     <= est_in;
         dev_ff     <= dev_in;
         timeout_ff <= timeout_in;
         done_ff    <= done_in;
         pend_ff    <= pend_in;
         if (csr_valid) begin
            case (csr_index)
               srsw_pkg::CSR_WINDOW_LENGTH: wl_ff    <= csr_wdata[4:0];
               srsw_pkg::CSR_TOTAL_PACKETS: total_ff <= csr_wdata;
               srsw_pkg::CSR_ADAPTIVE_MODE: adapt_ff <= csr_wdata[0];
               srsw_pkg::CSR_START_TIMEOUT: timeout_ff <= csr_wdata;
               default: wl_ff <= wl_ff;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      sample_ff   <= sample_in;
      slot_ff     <= slot_in;
      cnt_ff      <= cnt_in;
      res_kind_ff <= res_kind_in;
      res_seq_ff  <= res_seq_in;
   end

   // slot memory, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_wa] <= mem_wd;
      end
      rd_ff <= mem_ff[rd_addr];
   end

   // slot index of a sequence number
   srsw_mod #(
      .SEQ_BITS (SEQ_BITS),
      .CNT_W    (CNT_W),
      .SLOT_W   (SLOT_W)
   ) u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (mod_dividend),
      .divisor  (win),
      .done     (mod_done),
      .rem      (mod_rem)
   );
endmodule
